FILE: rtl/core/tspg_pkg.sv
// tspg_pkg: shared constants, types and state codes of the time smoothing
// penalty and gradient block; no dependencies
`default_nettype none

package tspg_pkg;

  localparam int MaxComponents = 32;
  localparam int MaxLevels     = 1024;

  localparam int CompW  = $clog2(MaxComponents);      // component index
  localparam int CplW   = 6;                          // components_per_level register
  localparam int LevelW = $clog2(MaxLevels);          // level index
  localparam int NlW    = 11;                         // level_count register
  localparam int WgtW   = 16;                         // Q4.12 weights
  localparam int ValW   = 16;                         // Q8.8 inputs
  localparam int DevW   = ValW + 1;                   // deviation
  localparam int GradW  = 48;
  localparam int AccW   = 64;
  localparam int TotalW = AccW - 1;
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 16;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_COMPONENTS   = 2'd0,
    CFG_LEVELS       = 2'd1,
    CFG_VALUE_WEIGHT = 2'd2,
    CFG_DIFF_WEIGHT  = 2'd3
  } tspg_cfg_idx_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CALC1,
    S_CALC2,
    S_CALC3,
    S_CALC4,
    S_FLUSH_RD,
    S_FLUSH_EMIT
  } tspg_state_e;

  // controller to datapath
  typedef struct packed {
    logic              load_in;     // request taken, capture deviation, read stores
    logic              calc1;
    logic              calc2;
    logic              calc3;       // also writes the stores
    logic              calc4;
    logic              has_prev;    // level above zero
    logic              flush_rd;
    logic              flush_emit;
    logic              flush_last;
    logic              acc_clear;
    logic [CompW-1:0]  addr;
    logic [LevelW-1:0] level;
    logic [WgtW-1:0]   value_weight;
    logic [WgtW-1:0]   diff_weight;
  } tspg_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic out_free;
  } tspg_status_t;

endpackage

`default_nettype wire

FILE: rtl/core/tspg_if.sv
// tspg_in_if and tspg_out_if: valid/ready channels of the block
// depends on tspg_pkg for field widths
`default_nettype none

interface tspg_in_if;
  import tspg_pkg::*;
  logic                   valid;
  logic                   ready;
  logic signed [ValW-1:0] param_value;
  logic signed [ValW-1:0] reference_value;

  modport source (output valid, output param_value, output reference_value, input ready);
  modport sink   (input valid, input param_value, input reference_value, output ready);
endinterface

interface tspg_out_if;
  import tspg_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [GradW-1:0] grad_value;
  logic [LevelW-1:0]       grad_level;
  logic [CompW-1:0]        grad_component;
  logic [TotalW-1:0]       penalty_total;
  logic                    final_result;

  modport source (output valid, output grad_value, output grad_level, output grad_component,
                  output penalty_total, output final_result, input ready);
  modport sink   (input valid, input grad_value, input grad_level, input grad_component,
                  input penalty_total, input final_result, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/tspg_ctrl.sv
// tspg_ctrl: configuration registers, level/component counters and the
// sequencing state machine; depends on tspg_pkg
`default_nettype none

module tspg_ctrl import tspg_pkg::*; (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i,
  input  wire logic                in_valid_i,
  output      logic                in_ready_o,
  input  wire tspg_status_t        status_i,
  output      tspg_cmd_t           cmd_o
);

  tspg_state_e       state_q, state_d;
  logic [CplW-1:0]   cpl_q;
  logic [NlW-1:0]    nl_q;
  logic [WgtW-1:0]   vw_q, dw_q;
  logic [CompW-1:0]  comp_q, comp_d;
  logic [LevelW-1:0] lvl_q, lvl_d;
  logic [CompW-1:0]  fl_q, fl_d;

  logic [CplW-1:0]   cpl_eff;
  logic [NlW-1:0]    nl_eff;
  logic [CplW-1:0]   comp_ext, comp_inc, fl_inc;
  logic [NlW-1:0]    lvl_ext, lvl_inc;
  logic              restart_need;
  logic              in_fire;

  // zero is used as one, oversized values clamp to the maximum
  always_comb begin
    if (cpl_q == '0) begin
      cpl_eff = CplW'(1);
    end else if (cpl_q > CplW'(MaxComponents)) begin
      cpl_eff = CplW'(MaxComponents);
    end else begin
      cpl_eff = cpl_q;
    end
    if (nl_q == '0) begin
      nl_eff = NlW'(1);
    end else if (nl_q > NlW'(MaxLevels)) begin
      nl_eff = NlW'(MaxLevels);
    end else begin
      nl_eff = nl_q;
    end
  end

  assign comp_ext     = {{(CplW-CompW){1'b0}}, comp_q};
  assign comp_inc     = comp_ext + CplW'(1);
  assign fl_inc       = {{(CplW-CompW){1'b0}}, fl_q} + CplW'(1);
  assign lvl_ext      = {{(NlW-LevelW){1'b0}}, lvl_q};
  assign lvl_inc      = lvl_ext + NlW'(1);
  assign restart_need = (comp_ext >= cpl_eff) || (lvl_ext >= nl_eff);
  assign in_ready_o   = (state_q == S_IDLE) && !cfg_we_i;
  assign in_fire      = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cpl_q <= CplW'(1);
      nl_q  <= NlW'(1);
      vw_q  <= '0;
      dw_q  <= '0;
    end else if (cfg_we_i) begin
      case (tspg_cfg_idx_e'(cfg_index_i))
        CFG_COMPONENTS:   cpl_q <= cfg_data_i[CplW-1:0];
        CFG_LEVELS:       nl_q  <= cfg_data_i[NlW-1:0];
        CFG_VALUE_WEIGHT: vw_q  <= cfg_data_i[WgtW-1:0];
        CFG_DIFF_WEIGHT:  dw_q  <= cfg_data_i[WgtW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      comp_q  <= '0;
      lvl_q   <= '0;
      fl_q    <= '0;
    end else begin
      state_q <= state_d;
      comp_q  <= comp_d;
      lvl_q   <= lvl_d;
      fl_q    <= fl_d;
    end
  end

  always_comb begin
    state_d = state_q;
    comp_d  = comp_q;
    lvl_d   = lvl_q;
    fl_d    = fl_q;
    cmd_o   = '0;
    cmd_o.value_weight = vw_q;
    cmd_o.diff_weight  = dw_q;
    cmd_o.has_prev     = (lvl_q != '0);
    cmd_o.addr         = comp_q;
    cmd_o.level        = lvl_q - LevelW'(1);

    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          cmd_o.load_in = 1'b1;
          if (restart_need) begin
            comp_d          = '0;
            lvl_d           = '0;
            cmd_o.addr      = '0;
            cmd_o.acc_clear = 1'b1;
          end
          state_d = S_CALC1;
        end
      end
      S_CALC1: begin
        cmd_o.calc1 = 1'b1;
        state_d     = S_CALC2;
      end
      S_CALC2: begin
        cmd_o.calc2 = 1'b1;
        state_d     = S_CALC3;
      end
      S_CALC3: begin
        // the gradient of the level above waits for a free output register
        if (!cmd_o.has_prev || status_i.out_free) begin
          cmd_o.calc3 = 1'b1;
          state_d     = S_CALC4;
        end
      end
      S_CALC4: begin
        cmd_o.calc4 = 1'b1;
        if (comp_inc >= cpl_eff) begin
          comp_d = '0;
          if (lvl_inc >= nl_eff) begin
            lvl_d   = '0;
            fl_d    = '0;
            state_d = S_FLUSH_RD;
          end else begin
            lvl_d   = lvl_inc[LevelW-1:0];
            state_d = S_IDLE;
          end
        end else begin
          comp_d  = comp_inc[CompW-1:0];
          state_d = S_IDLE;
        end
      end
      S_FLUSH_RD: begin
        cmd_o.flush_rd = 1'b1;
        cmd_o.addr     = fl_q;
        state_d        = S_FLUSH_EMIT;
      end
      S_FLUSH_EMIT: begin
        cmd_o.addr  = fl_q;
        cmd_o.level = LevelW'(nl_eff - NlW'(1));
        if (status_i.out_free) begin
          cmd_o.flush_emit = 1'b1;
          if (fl_inc >= cpl_eff) begin
            cmd_o.flush_last = 1'b1;
            cmd_o.acc_clear  = 1'b1;
            state_d          = S_IDLE;
          end else begin
            fl_d    = fl_inc[CompW-1:0];
            state_d = S_FLUSH_RD;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase

    // any register write restarts the set
    if (cfg_we_i) begin
      state_d         = S_IDLE;
      comp_d          = '0;
      lvl_d           = '0;
      fl_d            = '0;
      cmd_o.acc_clear = 1'b1;
    end
  end

  a_comp_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    comp_ext < cpl_eff)
    else $error("component counter beyond components per level");

  a_emit_needs_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.calc3 && cmd_o.has_prev) || cmd_o.flush_emit |-> status_i.out_free)
    else $error("result loaded into a full output register");

  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> state_q == S_CALC1)
    else $error("accepted request did not start the sequence");

  a_final_restarts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.flush_last |=> (comp_q == '0) && (lvl_q == '0) && (state_q == S_IDLE))
    else $error("set not restarted after final result");

endmodule

`default_nettype wire

FILE: rtl/core/tspg_dp.sv
// tspg_dp: deviation, products, saturating penalty accumulator, per-component
// stores and the output register; depends on tspg_pkg and tspg_out_if
`default_nettype none

module tspg_dp import tspg_pkg::*; (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire tspg_cmd_t              cmd_i,
  output      tspg_status_t           status_o,
  input  wire logic signed [ValW-1:0] param_value_i,
  input  wire logic signed [ValW-1:0] reference_value_i,
  tspg_out_if.source                  out_o
);

  function automatic logic [AccW-1:0] sat_add(input logic [AccW-1:0] a,
                                              input logic [AccW-1:0] b);
    logic [AccW:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[AccW] ? '1 : s[AccW-1:0];
  endfunction

  // per-component stores
  logic [DevW-1:0]  prev_mem [MaxComponents];
  logic [GradW-1:0] pend_mem [MaxComponents];

  logic signed [DevW-1:0] dev_q, prev_q;
  logic [GradW-1:0]       pend_q;
  logic signed [DevW:0]   diff_q;     // 18 bits
  logic [31:0]            sq_q;       // deviation squared
  logic signed [33:0]     g_q;        // value_weight * deviation
  logic [47:0]            term_q;     // value_weight * deviation squared
  logic [33:0]            dsq_q;      // difference squared
  logic signed [34:0]     bdd_q;      // diff_weight * difference
  logic [49:0]            term2_q;    // diff_weight * difference squared
  logic [AccW-1:0]        acc_q;

  logic signed [DevW-1:0] dev_d;
  logic signed [DevW:0]   diff_d;
  logic signed [33:0]     dd_prod, g_prod;
  logic [47:0]            term_prod;
  logic signed [35:0]     diff_sq;
  logic signed [34:0]     bdd_prod;
  logic [49:0]            term2_prod;
  logic [36:0]            g_new;
  logic [GradW:0]         gsub;
  logic [GradW-1:0]       grad_sat;
  logic                   emit_grad;

  logic                   out_valid_q;
  logic [GradW-1:0]       grad_q;
  logic [LevelW-1:0]      level_q;
  logic [CompW-1:0]       comp_q;
  logic [TotalW-1:0]      total_q;
  logic                   final_q;

  assign dev_d      = $signed({param_value_i[ValW-1], param_value_i})
                    - $signed({reference_value_i[ValW-1], reference_value_i});
  assign diff_d     = $signed({dev_q[DevW-1], dev_q}) - $signed({prev_q[DevW-1], prev_q});
  assign dd_prod    = dev_q * dev_q;
  assign g_prod     = $signed({1'b0, cmd_i.value_weight}) * dev_q;
  assign term_prod  = 48'(cmd_i.value_weight) * 48'(sq_q);
  assign diff_sq    = diff_q * diff_q;
  assign bdd_prod   = $signed({1'b0, cmd_i.diff_weight}) * diff_q;
  assign term2_prod = 50'(cmd_i.diff_weight) * 50'(dsq_q);

  assign g_new = {{3{g_q[33]}}, g_q}
               + (cmd_i.has_prev ? {{2{bdd_q[34]}}, bdd_q} : 37'd0);
  assign gsub  = {pend_q[GradW-1], pend_q} - {{(GradW-34){bdd_q[34]}}, bdd_q};
  always_comb begin
    if (gsub[GradW] != gsub[GradW-1]) begin
      grad_sat = gsub[GradW] ? {1'b1, {(GradW-1){1'b0}}} : {1'b0, {(GradW-1){1'b1}}};
    end else begin
      grad_sat = gsub[GradW-1:0];
    end
  end

  assign emit_grad         = cmd_i.calc3 && cmd_i.has_prev;
  assign status_o.out_free = !out_valid_q || out_o.ready;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      dev_q  <= dev_d;
      prev_q <= prev_mem[cmd_i.addr];
    end
    if (cmd_i.load_in || cmd_i.flush_rd) begin
      pend_q <= pend_mem[cmd_i.addr];
    end
    if (cmd_i.calc3) begin
      prev_mem[cmd_i.addr] <= dev_q;
      pend_mem[cmd_i.addr] <= {{(GradW-37){g_new[36]}}, g_new};
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.calc1) begin
      diff_q <= diff_d;
      sq_q   <= dd_prod[31:0];
      g_q    <= g_prod;
    end
    if (cmd_i.calc2) begin
      term_q <= term_prod;
      dsq_q  <= diff_sq[33:0];
      bdd_q  <= bdd_prod;
    end
    if (cmd_i.calc3) begin
      term2_q <= term2_prod;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else if (cmd_i.acc_clear) begin
      acc_q <= '0;
    end else if (cmd_i.calc3) begin
      acc_q <= sat_add(acc_q, {{(AccW-48){1'b0}}, term_q});
    end else if (cmd_i.calc4 && cmd_i.has_prev) begin
      acc_q <= sat_add(acc_q, {{(AccW-50){1'b0}}, term2_q});
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit_grad || cmd_i.flush_emit) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit_grad || cmd_i.flush_emit) begin
      grad_q  <= cmd_i.flush_emit ? pend_q : grad_sat;
      level_q <= cmd_i.level;
      comp_q  <= cmd_i.addr;
      total_q <= cmd_i.flush_last ? acc_q[AccW-1:1] : '0;
      final_q <= cmd_i.flush_last;
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.grad_value     = grad_q;
  assign out_o.grad_level     = level_q;
  assign out_o.grad_component = comp_q;
  assign out_o.penalty_total  = total_q;
  assign out_o.final_result   = final_q;

endmodule

`default_nettype wire

FILE: rtl/core/time_smoothing_penalty_and_gradient.sv
// time_smoothing_penalty_and_gradient: top level, joins tspg_ctrl and tspg_dp
// depends on tspg_pkg, tspg_in_if, tspg_out_if, tspg_ctrl, tspg_dp
//
// usage
//   in_i carries one (param_value, reference_value) request per item, Q8.8,
//   in level-major order: level 0 components 0..C-1, then level 1, and so on
//   out_o carries gradient results; the gradient of level L, component c
//   leaves when the request of level L+1, component c is worked; the last
//   request of a set flushes the whole last level, and the final of those
//   results carries penalty_total with final_result set
//   cfg_we_i/cfg_index_i/cfg_data_i write the four registers; any write
//   restarts the set (counters and penalty accumulator cleared)
// timing
//   one request is taken in the acceptance cycle and then worked in four steps of
//   the multiply datapath (deviation products, weighted squares, then two
//   accumulator adds), each product registered before the next use
//   a gradient result is loaded into the output register in the first of the two
//   accumulator add steps; the last request of a set is followed by a flush of each
//   component (store read, then output load)
// reset and stalls
//   reset sets components_per_level and level_count to one, weights to zero,
//   clears counters, accumulator and the output valid flag
//   a stalled receiver holds the output register; the sequencer then waits
//   in the step that would load it, and no new request is taken meanwhile
`default_nettype none

module time_smoothing_penalty_and_gradient import tspg_pkg::*; (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i,
  tspg_in_if.sink                  in_i,
  tspg_out_if.source               out_o
);

  tspg_cmd_t    cmd;
  tspg_status_t status;
  logic         in_ready;

  // sequencer, configuration and counters
  tspg_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // request ready only while the sequencer waits for work and no register is written
  assign in_i.ready = in_ready;

  // arithmetic, stores and output register
  tspg_dp u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .status_o          (status),
    .param_value_i     (in_i.param_value),
    .reference_value_i (in_i.reference_value),
    .out_o             (out_o)
  );

endmodule

`default_nettype wire
